FILE: src/programmable_interrupt_controller_assert.svh
// assertion macros shared by the checker
`ifndef PROGRAMMABLE_INTERRUPT_CONTROLLER_ASSERT_SVH
`define PROGRAMMABLE_INTERRUPT_CONTROLLER_ASSERT_SVH
`define PIC_ASSERT_IMPL(lbl, a, c) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (a) |-> (c)) \
        else $error("pic check failed");
`define PIC_ASSERT_NEXT(lbl, a, c) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (a) |=> (c)) \
        else $error("pic check failed");
`endif

FILE: src/pic_pkg.sv
`default_nettype none
package pic_pkg;
    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_LINE  = 2'd2;
    localparam logic [1:0] MODE_ACK   = 2'd3;
    localparam logic [1:0] CFG_LEVEL_SELECT = 2'd0;
    localparam logic [1:0] CFG_PER_LINE     = 2'd1;
    localparam logic [1:0] CFG_REJECT_HIGH  = 2'd2;
    localparam logic [7:0] SEL_NONE = 8'h17;

    typedef struct packed {
        logic [1:0] mode;
        logic       addr_bit;
        logic [7:0] write_data;
        logic [2:0] irq_line;
        logic       irq_assert;
        logic       irq_counted;
        logic       source_was_asserted;
    } pic_item_t;

    typedef struct packed {
        logic load;    // capture input word
        logic exec;    // apply captured word to state
    } pic_cmd_t;
endpackage
`default_nettype wire

FILE: src/programmable_interrupt_controller.sv
`default_nettype none
// 8259-style interrupt controller, one bus event per word: register write, register
// read, irq line change or acknowledge cycle; every input word yields exactly one result
// word carrying the data bus byte, the int request and the selected line. a word passes
// through capture, execute and present, and the next is taken only once the result has
// been accepted. configuration is a plain write port: index 0 level_select, 1 per_line_level_enable,
// 2 reject_high_init.
module programmable_interrupt_controller #(
    parameter int SOURCES_PER_LINE = 15
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [1:0] s_mode,
    input  wire logic       s_addr_bit,
    input  wire logic [7:0] s_write_data,
    input  wire logic [2:0] s_irq_line,
    input  wire logic       s_irq_assert,
    input  wire logic       s_irq_counted,
    input  wire logic       s_source_was_asserted,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_read_data,
    output logic            m_int_request,
    output logic [2:0]      m_chosen_line,
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_data
);
    import pic_pkg::*;
    pic_cmd_t  cmd;
    pic_item_t item;

    // bundle the input word fields
    assign item = '{mode: s_mode, addr_bit: s_addr_bit, write_data: s_write_data,
                    irq_line: s_irq_line, irq_assert: s_irq_assert,
                    irq_counted: s_irq_counted,
                    source_was_asserted: s_source_was_asserted};

    pic_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .cmd(cmd)
    );

    pic_datapath #(.SOURCES_PER_LINE(SOURCES_PER_LINE)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .item(item),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .read_data(m_read_data), .int_request(m_int_request),
        .chosen_line(m_chosen_line)
    );
endmodule
`default_nettype wire

FILE: src/pic_ctrl.sv
`default_nettype none
module pic_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output pic_pkg::pic_cmd_t      cmd
);
    import pic_pkg::*;
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;
    logic [1:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        s_ready = 1'b0;
        m_valid = 1'b0;
        cmd = '0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else          state_reg <= state_next;
    end
endmodule
`default_nettype wire

FILE: src/pic_datapath.sv
`default_nettype none
module pic_datapath #(
    parameter int SOURCES_PER_LINE = 15
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire pic_pkg::pic_cmd_t cmd,
    input  wire pic_pkg::pic_item_t item,
    input  wire logic              cfg_we,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [7:0]        cfg_data,
    output logic [7:0]             read_data,
    output logic                   int_request,
    output logic [2:0]             chosen_line
);
    import pic_pkg::*;
    localparam int CW = $clog2(SOURCES_PER_LINE + 1);
    localparam logic [CW-1:0] CMAX = CW'(SOURCES_PER_LINE);

    pic_item_t it_reg;
    logic [7:0] lsel_reg; logic perl_reg, rej_reg;
    logic [1:0] step_reg, step_next;
    logic [7:0] icw1_reg, icw1_next, vb_reg, vb_next, cas_reg, cas_next;
    logic [7:0] icw4_reg, icw4_next, lc_reg, lc_next, rs_reg, rs_next;
    logic [7:0] irr_reg, irr_next, imr_reg, imr_next, isr_reg, isr_next;
    logic [2:0] lpb_reg, lpb_next;
    logic [1:0] ph_reg, ph_next;
    logic rae_reg, rae_next, smm_reg, smm_next, pf_reg, pf_next;
    logic [7:0] sc_reg, sc_next, bl_reg, bl_next;
    logic [CW-1:0] cnt_reg [8];
    logic [CW-1:0] cnt_next [8];

    function automatic logic lvl(input logic [2:0] ln, input logic pe,
                                 input logic [7:0] ls, input logic [7:0] w1);
        return pe ? ls[ln] : w1[3];
    endfunction

    // rotating priority pick, frozen when bit 5 of the code is set
    task automatic refresh(inout logic [7:0] sc, inout logic pf,
                           input logic [7:0] isr, input logic [7:0] irr,
                           input logic [7:0] imr, input logic [1:0] stp,
                           input logic [2:0] lpb);
        logic done; logic [2:0] ln; logic found; logic [2:0] best;
        done = 1'b0; found = 1'b0; best = '0;
        if (!sc[5]) begin
            for (int k = 0; k < 8; k++) begin
                ln = lpb + 3'(k);
                if (!done) begin
                    if (isr[ln]) done = 1'b1;
                    else if (stp == 2'd0 && irr[ln] && !imr[ln]) begin
                        done = 1'b1; found = 1'b1; best = ln;
                    end
                end
            end
            sc = found ? {5'd0, best} : SEL_NONE;
            pf = found;
        end
    endtask

    function automatic logic [3:0] top_is(input logic [7:0] isr,
            input logic [7:0] imr, input logic smm, input logic [2:0] lpb);
        logic [3:0] r; logic [2:0] ln;
        r = 4'd8;
        for (int k = 7; k >= 0; k--) begin
            ln = lpb + 3'(k);
            if (isr[ln] && (!smm || !imr[ln])) r = {1'b0, ln};
        end
        return r;
    endfunction

    always_comb begin
        logic [2:0] ln; logic [3:0] tl; logic x86, set, chg, hit;
        logic [CW-1:0] c;
        logic [1:0] phn;
        step_next = step_reg; icw1_next = icw1_reg; vb_next = vb_reg;
        cas_next = cas_reg; icw4_next = icw4_reg; lc_next = lc_reg;
        rs_next = rs_reg; irr_next = irr_reg; imr_next = imr_reg;
        isr_next = isr_reg; lpb_next = lpb_reg; ph_next = ph_reg;
        rae_next = rae_reg; smm_next = smm_reg; pf_next = pf_reg;
        sc_next = sc_reg; bl_next = bl_reg;
        for (int i = 0; i < 8; i++) cnt_next[i] = cnt_reg[i];
        ln = '0; tl = '0; x86 = 1'b0; set = 1'b0; chg = 1'b0; hit = 1'b1;
        c = '0; phn = '0;
        case (it_reg.mode)
            MODE_WRITE: begin
                bl_next = it_reg.write_data;
                if (it_reg.addr_bit) begin
                    case (step_reg)
                        2'd1: begin
                            vb_next = it_reg.write_data;
                            if (!icw1_reg[1]) step_next = 2'd2;
                            else step_next = icw1_reg[0] ? 2'd3 : 2'd0;
                        end
                        2'd2: begin
                            cas_next = it_reg.write_data;
                            step_next = icw1_reg[0] ? 2'd3 : 2'd0;
                        end
                        2'd3: begin
                            icw4_next = it_reg.write_data; step_next = 2'd0;
                        end
                        default: begin
                            imr_next = it_reg.write_data;
                            refresh(sc_next, pf_next, isr_next, irr_next,
                                    imr_next, step_next, lpb_next);
                        end
                    endcase
                end else if (it_reg.write_data[4]) begin
                    if (!(rej_reg && (it_reg.write_data[7:5] != 3'd0))) begin
                        icw1_next = it_reg.write_data;
                        vb_next = '0; cas_next = '0;
                        if (!it_reg.write_data[0]) icw4_next = '0;
                        lc_next = '0; rs_next = '0;
                        for (int i = 0; i < 8; i++) irr_next[i] = (cnt_reg[i] != '0);
                        imr_next = '0; isr_next = '0; ph_next = '0; lpb_next = '0;
                        rae_next = 1'b0; smm_next = 1'b0; sc_next = SEL_NONE;
                        pf_next = 1'b0; step_next = 2'd1;
                    end
                end else if (it_reg.write_data[3]) begin
                    rs_next = it_reg.write_data;
                    if (it_reg.write_data[2]) sc_next[5] = 1'b1;
                    if (it_reg.write_data[6]) smm_next = it_reg.write_data[5];
                end else begin
                    lc_next = it_reg.write_data;
                    if (it_reg.write_data[6:5] != 2'd0) begin
                        tl = it_reg.write_data[6] ? {1'b0, it_reg.write_data[2:0]}
                                                  : top_is(isr_reg, imr_reg, smm_reg, lpb_reg);
                        if (!tl[3]) begin
                            if (it_reg.write_data[5]) isr_next[tl[2:0]] = 1'b0;
                            if (it_reg.write_data[7]) lpb_next = tl[2:0] + 3'd1;
                            refresh(sc_next, pf_next, isr_next, irr_next,
                                    imr_next, step_next, lpb_next);
                        end
                    end else rae_next = it_reg.write_data[7];
                end
            end
            MODE_READ: begin
                bl_next = irr_reg;
                if (rs_reg[2]) begin
                    sc_next[5] = 1'b0;
                    if (pf_reg) begin
                        ln = sc_reg[2:0];
                        bl_next = {5'b10000, ln};
                        isr_next[ln] = 1'b1;
                        if (!lvl(ln, perl_reg, lsel_reg, icw1_reg) || cnt_reg[ln] == '0)
                            irr_next[ln] = 1'b0;
                        pf_next = 1'b0;
                        refresh(sc_next, pf_next, isr_next, irr_next,
                                imr_next, step_next, lpb_next);
                    end else bl_next = '0;
                    rs_next[2] = 1'b0;
                end else if (it_reg.addr_bit) bl_next = imr_reg;
                else if (rs_reg[1:0] == 2'b11) bl_next = isr_reg;
            end
            MODE_LINE: begin
                ln = it_reg.irq_line; set = it_reg.irq_assert;
                if (it_reg.irq_counted) begin
                    chg = it_reg.source_was_asserted != set;
                    c = cnt_reg[ln];
                    if (chg) begin
                        if (set) begin if (c < CMAX) c = c + 1'b1; end
                        else if (c != '0) c = c - 1'b1;
                    end
                    cnt_next[ln] = c;
                    hit = !lvl(ln, perl_reg, lsel_reg, icw1_reg) ||
                          (chg && c == (set ? CW'(1) : CW'(0)));
                end
                if (hit) begin
                    irr_next[ln] = set;
                    refresh(sc_next, pf_next, isr_next, irr_next,
                            imr_next, step_next, lpb_next);
                end
            end
            default: begin
                ln = sc_reg[2:0]; x86 = icw4_reg[0];
                if (ph_reg == 2'd0) begin
                    sc_next[5] = 1'b1;
                    isr_next[ln] = 1'b1;
                    if (!lvl(ln, perl_reg, lsel_reg, icw1_reg) || cnt_reg[ln] == '0)
                        irr_next[ln] = 1'b0;
                    bl_next = x86 ? 8'hff : 8'hcd;
                end else if (x86 || ph_reg != 2'd1) begin
                    pf_next = 1'b0;
                    bl_next = x86 ? ({5'd0, ln} + (vb_reg & 8'hf8)) : vb_reg;
                    if (icw4_reg[1]) begin
                        tl = top_is(isr_next, imr_next, smm_next, lpb_next);
                        if (!tl[3]) begin
                            isr_next[tl[2:0]] = 1'b0;
                            if (rae_reg) lpb_next = tl[2:0] + 3'd1;
                            refresh(sc_next, pf_next, isr_next, irr_next,
                                    imr_next, step_next, lpb_next);
                        end
                    end
                end else if (icw1_reg[2]) bl_next = {3'd0, ln, 2'd0} + (icw1_reg & 8'he0);
                else bl_next = {2'd0, ln, 3'd0} + (icw1_reg & 8'hc0);
                if (x86) phn = {1'b0, ~ph_reg[0]};
                else if (ph_reg == 2'd2) phn = 2'd0;
                else if (ph_reg == 2'd3) phn = 2'd1;
                else phn = ph_reg + 2'd1;
                ph_next = phn;
                if (phn == 2'd0) begin
                    sc_next = SEL_NONE;
                    refresh(sc_next, pf_next, isr_next, irr_next,
                            imr_next, step_next, lpb_next);
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) it_reg <= item;
        if (!aresetn) begin
            lsel_reg <= '0; perl_reg <= 1'b0; rej_reg <= 1'b0;
            step_reg <= '0; icw1_reg <= '0; vb_reg <= '0; cas_reg <= '0;
            icw4_reg <= '0; lc_reg <= '0; rs_reg <= '0; irr_reg <= '0;
            imr_reg <= '0; isr_reg <= '0; lpb_reg <= '0; ph_reg <= '0;
            rae_reg <= 1'b0; smm_reg <= 1'b0; sc_reg <= SEL_NONE;
            pf_reg <= 1'b0; bl_reg <= '0;
            for (int i = 0; i < 8; i++) cnt_reg[i] <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_LEVEL_SELECT: lsel_reg <= cfg_data;
                    CFG_PER_LINE:     perl_reg <= cfg_data[0];
                    CFG_REJECT_HIGH:  rej_reg  <= cfg_data[0];
                    default: ;
                endcase
            end
            if (cmd.exec) begin
                step_reg <= step_next; icw1_reg <= icw1_next; vb_reg <= vb_next;
                cas_reg <= cas_next; icw4_reg <= icw4_next; lc_reg <= lc_next;
                rs_reg <= rs_next; irr_reg <= irr_next; imr_reg <= imr_next;
                isr_reg <= isr_next; lpb_reg <= lpb_next; ph_reg <= ph_next;
                rae_reg <= rae_next; smm_reg <= smm_next; sc_reg <= sc_next;
                pf_reg <= pf_next; bl_reg <= bl_next;
                for (int i = 0; i < 8; i++) cnt_reg[i] <= cnt_next[i];
            end
        end
    end

    assign read_data   = bl_reg;
    assign int_request = pf_reg;
    assign chosen_line = sc_reg[2:0];
endmodule
`default_nettype wire

FILE: src/pic_checker.sv
`default_nettype none
`include "programmable_interrupt_controller_assert.svh"
module pic_checker (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_valid,
    input wire logic s_ready,
    input wire logic m_valid,
    input wire logic m_ready,
    input wire logic [7:0] m_read_data
);
    // one word in flight at a time
    `PIC_ASSERT_IMPL(a_excl, m_valid, !s_ready)
    // an accepted input is executed before its result is offered, and no new input is taken meanwhile
    `PIC_ASSERT_NEXT(a_exec, s_valid && s_ready, !m_valid && !s_ready)
    // result holds while stalled
    `PIC_ASSERT_NEXT(a_hold, m_valid && !m_ready, m_valid && $stable(m_read_data))
endmodule
bind programmable_interrupt_controller pic_checker u_pic_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_read_data(m_read_data)
);
`default_nettype wire

FILE: dv/programmable_interrupt_controller_test.sv
`default_nettype none
module programmable_interrupt_controller_test;
    import pic_pkg::*;

    // ocw / icw bit groups used when building words
    localparam logic [7:0] ICW1_BASE = 8'h10;
    localparam logic [7:0] OCW3_BASE = 8'h08;
    localparam logic [7:0] OCW3_POLL = 8'h0c;
    localparam logic [7:0] OCW3_READ_ISR = 8'h0b;
    localparam logic [7:0] OCW3_READ_IRR = 8'h0a;
    localparam logic [7:0] OCW2_NS_EOI = 8'h20;
    localparam logic [7:0] OCW2_SP_EOI = 8'h60;
    localparam logic [7:0] OCW2_ROT_NS = 8'ha0;
    localparam logic [7:0] OCW2_ROT_SP = 8'he0;
    localparam logic [7:0] OCW2_SET_PRI = 8'hc0;
    localparam logic [7:0] OCW2_AEOI_ROT_ON = 8'h80;
    localparam logic [7:0] OCW2_AEOI_ROT_OFF = 8'h00;
    localparam int COUNT_MAX = 15;
    localparam int WATCHDOG_LIMIT = 20000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [1:0] s_mode = MODE_WRITE;
    logic s_addr_bit = 1'b0;
    logic [7:0] s_write_data = 8'h00;
    logic [2:0] s_irq_line = 3'd0;
    logic s_irq_assert = 1'b0;
    logic s_irq_counted = 1'b0;
    logic s_source_was_asserted = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [7:0] m_read_data;
    logic m_int_request;
    logic [2:0] m_chosen_line;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = CFG_LEVEL_SELECT;
    logic [7:0] cfg_data = 8'h00;

    always #4 aclk = ~aclk;

    programmable_interrupt_controller uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_mode(s_mode),
        .s_addr_bit(s_addr_bit), .s_write_data(s_write_data),
        .s_irq_line(s_irq_line), .s_irq_assert(s_irq_assert),
        .s_irq_counted(s_irq_counted), .s_source_was_asserted(s_source_was_asserted),
        .m_valid(m_valid), .m_ready(m_ready), .m_read_data(m_read_data),
        .m_int_request(m_int_request), .m_chosen_line(m_chosen_line),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    typedef struct packed {
        logic [7:0] bus_byte;
        logic       int_req;
        logic [2:0] line;
    } pic_result_t;

    // controller shadow state
    logic [7:0] sh_level_sel;
    logic sh_per_line;
    logic sh_reject_high;
    logic [1:0] sh_init_step;
    logic [7:0] sh_icw1, sh_vector, sh_cascade, sh_icw4, sh_ocw2, sh_ocw3;
    logic [7:0] sh_irr, sh_imr, sh_isr;
    logic [2:0] sh_base;
    logic [1:0] sh_ack_phase;
    logic sh_aeoi_rotate, sh_smm;
    logic [7:0] sh_sel;
    logic sh_pending;
    int sh_count [8];
    logic [7:0] sh_latch;
    // per-line/per-source asserted state used to generate sensible counted changes
    logic src_state [8][4];

    pic_result_t expected_results[$];
    int mismatches = 0;
    int words_sent = 0;
    int results_seen = 0;
    int acks_sent = 0;
    int polls_sent = 0;
    int idle_pct = 36;
    bit rx_hold = 1'b0;
    bit done = 1'b0;
    int quiet_cycles = 0;

    function automatic bit line_is_level(input logic [2:0] ln);
        if (sh_per_line) return sh_level_sel[ln];
        return sh_icw1[3];
    endfunction

    task automatic pick_highest();
        int k;
        int best;
        logic [2:0] ln;
        best = -1;
        if (sh_sel[5]) return;
        for (k = 0; k < 8; k++) begin
            ln = 3'(k + sh_base);
            if (sh_isr[ln]) break;
            if (sh_init_step == 2'd0 && sh_irr[ln] && !sh_imr[ln]) begin
                best = ln;
                break;
            end
        end
        sh_sel = (best < 0) ? SEL_NONE : 8'(best);
        sh_pending = (best >= 0);
    endtask

    task automatic take_line();
        logic [2:0] ln;
        ln = sh_sel[2:0];
        sh_isr[ln] = 1'b1;
        if (!line_is_level(ln) || sh_count[ln] == 0) sh_irr[ln] = 1'b0;
    endtask

    function automatic int top_serviced();
        int k;
        logic [2:0] ln;
        for (k = 0; k < 8; k++) begin
            ln = 3'(k + sh_base);
            if (sh_isr[ln] && (!sh_smm || !sh_imr[ln])) return ln;
        end
        return 8;
    endfunction

    task automatic end_service(input int ln, input bit eoi, input bit rot);
        if (ln > 7) return;
        if (eoi) sh_isr[ln] = 1'b0;
        if (rot) sh_base = 3'(ln + 1);
        pick_highest();
    endtask

    task automatic reg_write(input logic a0, input logic [7:0] v);
        int i;
        sh_latch = v;
        if (a0) begin
            case (sh_init_step)
                2'd1: begin
                    sh_vector = v;
                    if (!sh_icw1[1]) sh_init_step = 2'd2;
                    else sh_init_step = sh_icw1[0] ? 2'd3 : 2'd0;
                end
                2'd2: begin
                    sh_cascade = v;
                    sh_init_step = sh_icw1[0] ? 2'd3 : 2'd0;
                end
                2'd3: begin
                    sh_icw4 = v;
                    sh_init_step = 2'd0;
                end
                default: begin
                    sh_imr = v;
                    pick_highest();
                end
            endcase
        end else if (v[4]) begin
            if (sh_reject_high && v[7:5] != 3'd0) return;
            sh_icw1 = v;
            sh_vector = 8'h00;
            sh_cascade = 8'h00;
            if (!v[0]) sh_icw4 = 8'h00;
            sh_ocw2 = 8'h00;
            sh_ocw3 = 8'h00;
            sh_irr = 8'h00;
            for (i = 0; i < 8; i++) if (sh_count[i] > 0) sh_irr[i] = 1'b1;
            sh_imr = 8'h00;
            sh_isr = 8'h00;
            sh_ack_phase = 2'd0;
            sh_base = 3'd0;
            sh_aeoi_rotate = 1'b0;
            sh_smm = 1'b0;
            sh_sel = SEL_NONE;
            sh_pending = 1'b0;
            sh_init_step = 2'd1;
            pick_highest();
        end else if (v[3]) begin
            sh_ocw3 = v;
            if (v[2]) sh_sel[5] = 1'b1;
            if (v[6]) sh_smm = v[5];
        end else begin
            sh_ocw2 = v;
            if (v[6:5] != 2'b00)
                end_service(v[6] ? int'(v[2:0]) : top_serviced(), v[5], v[7]);
            else
                sh_aeoi_rotate = v[7];
        end
    endtask

    task automatic reg_read(input logic a0);
        sh_latch = sh_irr;
        if (sh_ocw3[2]) begin
            sh_sel[5] = 1'b0;
            if (sh_pending) begin
                sh_latch = 8'h80 | {5'd0, sh_sel[2:0]};
                take_line();
                sh_pending = 1'b0;
                pick_highest();
            end else begin
                sh_latch = 8'h00;
            end
            sh_ocw3[2] = 1'b0;
        end else if (a0) begin
            sh_latch = sh_imr;
        end else if (sh_ocw3[1:0] == 2'b11) begin
            sh_latch = sh_isr;
        end
    endtask

    task automatic line_change(input pic_item_t it);
        logic [2:0] ln;
        bit hit;
        bit changed;
        ln = it.irq_line;
        hit = 1'b1;
        if (it.irq_counted) begin
            changed = (it.source_was_asserted != it.irq_assert);
            if (changed) begin
                if (it.irq_assert) begin
                    if (sh_count[ln] < COUNT_MAX) sh_count[ln]++;
                end else if (sh_count[ln] > 0) begin
                    sh_count[ln]--;
                end
            end
            hit = !line_is_level(ln) ||
                (changed && sh_count[ln] == (it.irq_assert ? 1 : 0));
        end
        if (!hit) return;
        sh_irr[ln] = it.irq_assert;
        pick_highest();
    endtask

    task automatic ack_cycle();
        logic [2:0] ln;
        bit x86;
        ln = sh_sel[2:0];
        x86 = sh_icw4[0];
        if (sh_ack_phase == 2'd0) begin
            sh_sel[5] = 1'b1;
            take_line();
            sh_latch = x86 ? 8'hff : 8'hcd;
        end else if (x86 || sh_ack_phase != 2'd1) begin
            sh_pending = 1'b0;
            sh_latch = x86 ? 8'(ln + (sh_vector & 8'hf8)) : sh_vector;
            if (sh_icw4[1]) end_service(top_serviced(), 1'b1, sh_aeoi_rotate);
        end else if (sh_icw1[2]) begin
            sh_latch = 8'({ln, 2'b00} + (sh_icw1 & 8'he0));
        end else begin
            sh_latch = 8'({ln, 3'b000} + (sh_icw1 & 8'hc0));
        end
        sh_ack_phase = 2'((sh_ack_phase + 1) % (x86 ? 2 : 3));
        if (sh_ack_phase == 2'd0) begin
            sh_sel = SEL_NONE;
            pick_highest();
        end
    endtask

    task automatic predict_word(input pic_item_t it);
        case (it.mode)
            MODE_WRITE: reg_write(it.addr_bit, it.write_data);
            MODE_READ: reg_read(it.addr_bit);
            MODE_LINE: line_change(it);
            default: ack_cycle();
        endcase
        expected_results.push_back('{sh_latch, sh_pending, sh_sel[2:0]});
    endtask

    task automatic shadow_reset();
        sh_level_sel = 8'h00; sh_per_line = 1'b0; sh_reject_high = 1'b0;
        sh_init_step = 2'd0; sh_icw1 = 8'h00; sh_vector = 8'h00;
        sh_cascade = 8'h00; sh_icw4 = 8'h00; sh_ocw2 = 8'h00; sh_ocw3 = 8'h00;
        sh_irr = 8'h00; sh_imr = 8'h00; sh_isr = 8'h00; sh_base = 3'd0;
        sh_ack_phase = 2'd0; sh_aeoi_rotate = 1'b0; sh_smm = 1'b0;
        sh_sel = SEL_NONE; sh_pending = 1'b0; sh_latch = 8'h00;
        for (int i = 0; i < 8; i++) begin
            sh_count[i] = 0;
            for (int j = 0; j < 4; j++) src_state[i][j] = 1'b0;
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("mismatch on result %0d: %s got %0h expected %0h",
            results_seen, what, got, want);
    endtask

    // one word on the input channel; prediction happens at acceptance
    task automatic send_word(input pic_item_t it);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct) @(posedge aclk);
        s_valid <= 1'b1;
        s_mode <= it.mode;
        s_addr_bit <= it.addr_bit;
        s_write_data <= it.write_data;
        s_irq_line <= it.irq_line;
        s_irq_assert <= it.irq_assert;
        s_irq_counted <= it.irq_counted;
        s_source_was_asserted <= it.source_was_asserted;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_word(it);
        words_sent++;
        if (it.mode == MODE_ACK) acks_sent++;
        s_valid <= 1'b0;
        // the block is busy with this word anyway, so no new word can be taken yet
        @(posedge aclk);
    endtask

    task automatic wr(input logic a0, input logic [7:0] v);
        pic_item_t it;
        it = '0;
        it.mode = MODE_WRITE;
        it.addr_bit = a0;
        it.write_data = v;
        send_word(it);
    endtask

    task automatic rd(input logic a0);
        pic_item_t it;
        it = '0;
        it.mode = MODE_READ;
        it.addr_bit = a0;
        it.write_data = 8'($urandom);
        send_word(it);
    endtask

    task automatic ack();
        pic_item_t it;
        it = '0;
        it.mode = MODE_ACK;
        it.irq_line = 3'($urandom);
        send_word(it);
    endtask

    // plain line change, or a counted change by one of four tracked sources
    task automatic irq(input logic [2:0] ln, input bit lvl, input bit counted);
        pic_item_t it;
        int src;
        it = '0;
        it.mode = MODE_LINE;
        it.irq_line = ln;
        it.irq_assert = lvl;
        it.irq_counted = counted;
        it.write_data = 8'($urandom);
        if (counted) begin
            src = $urandom_range(3);
            it.source_was_asserted = ($urandom_range(9) == 0) ? 1'($urandom_range(1))
                : src_state[ln][src];
            src_state[ln][src] = lvl;
        end
        send_word(it);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [7:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_LEVEL_SELECT: sh_level_sel = v;
            CFG_PER_LINE: sh_per_line = v[0];
            default: sh_reject_high = v[0];
        endcase
        @(posedge aclk);
    endtask

    task automatic drain();
        while (expected_results.size() > 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    // icw sequence with optional cascade and icw4
    task automatic init_pic(input logic [7:0] icw1, input logic [7:0] vec,
                            input logic [7:0] icw4);
        wr(1'b0, icw1 | ICW1_BASE);
        wr(1'b1, vec);
        if (!icw1[1]) wr(1'b1, 8'($urandom));
        if (icw1[0]) wr(1'b1, icw4);
    endtask

    task automatic test_directed();
        init_pic(8'h11, 8'h08, 8'h01);
        rd(1'b1);
        irq(3'd0, 1'b1, 1'b0);
        irq(3'd7, 1'b1, 1'b0);
        ack();
        ack();
        wr(1'b0, OCW3_READ_ISR);
        rd(1'b0);
        wr(1'b0, OCW2_NS_EOI);
        wr(1'b1, 8'hff);
        wr(1'b1, 8'h00);
        ack();
        ack();
        wr(1'b0, OCW2_SP_EOI | 8'h07);
        wr(1'b0, OCW3_POLL);
        rd(1'b0);
        wr(1'b0, OCW2_ROT_SP | 8'h03);
        wr(1'b0, OCW2_SET_PRI | 8'h05);
        wr(1'b0, 8'h6b);
        wr(1'b0, OCW3_READ_IRR);
        rd(1'b0);
        init_pic(8'hf6, 8'hff, 8'h00);
        irq(3'd2, 1'b1, 1'b0);
        ack(); ack(); ack();
        drain();
    endtask

    task automatic test_level_counting();
        cfg_write(CFG_LEVEL_SELECT, 8'hff);
        cfg_write(CFG_PER_LINE, 8'h01);
        init_pic(8'h13, 8'h40, 8'h03);
        for (int i = 0; i < 40; i++) irq(3'($urandom_range(1)), 1'b1, 1'b1);
        for (int i = 0; i < 40; i++) irq(3'($urandom_range(1)), 1'b0, 1'b1);
        for (int i = 0; i < 60; i++)
            if (i % 3 == 0) ack(); else irq(3'($urandom), 1'($urandom), 1'b1);
        drain();
        cfg_write(CFG_LEVEL_SELECT, 8'h00);
        cfg_write(CFG_PER_LINE, 8'h00);
    endtask

    task automatic test_reject_high();
        cfg_write(CFG_REJECT_HIGH, 8'h01);
        wr(1'b0, 8'hf1);
        wr(1'b0, 8'h13);
        wr(1'b1, 8'h20);
        wr(1'b1, 8'h02);
        drain();
        cfg_write(CFG_REJECT_HIGH, 8'h00);
    endtask

    // mostly proper sessions: init, line activity, acks, eoi, some noise
    task automatic random_session(input int words);
        logic [7:0] icw1;
        int r;
        icw1 = 8'($urandom);
        icw1[0] = $urandom_range(3) != 0;
        init_pic(icw1, 8'($urandom), {6'($urandom), 1'($urandom), 1'($urandom)});
        for (int i = 0; i < words; i++) begin
            r = $urandom_range(99);
            if (r < 30) irq(3'($urandom), 1'($urandom), 1'($urandom));
            else if (r < 50) ack();
            else if (r < 58) rd(1'($urandom));
            else if (r < 66) wr(1'b0, {3'($urandom), 2'b00, 3'($urandom)});
            else if (r < 72) wr(1'b0, {1'b0, 2'($urandom), 2'b01, 3'($urandom)});
            else if (r < 78) begin
                wr(1'b0, OCW3_POLL);
                rd(1'($urandom));
                polls_sent++;
            end
            else if (r < 84) wr(1'b1, 8'($urandom));
            else if (r < 86) wr(1'b0, 8'($urandom));
            else rd(1'b0);
        end
    endtask

    task automatic test_random();
        for (int s = 0; s < 24; s++) begin
            idle_pct = (s == 5 || s == 6) ? 0 : 36;
            if (s % 6 == 3) begin
                drain();
                cfg_write(CFG_LEVEL_SELECT, 8'($urandom));
                cfg_write(CFG_PER_LINE, 8'($urandom_range(1)));
                cfg_write(CFG_REJECT_HIGH, 8'($urandom_range(1)));
            end
            random_session(45 + $urandom_range(20));
        end
        idle_pct = 36;
        drain();
    endtask

    // receiver holds off while the sender keeps offering words
    task automatic test_backpressure();
        rx_hold = 1'b1;
        fork
            begin
                repeat (300) @(posedge aclk);
                rx_hold = 1'b0;
            end
            random_session(40);
        join
        drain();
    endtask

    // result side: random stalls, honors long hold-off
    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else m_ready <= !rx_hold && (idle_pct == 0 || $urandom_range(99) >= idle_pct);
    end

    always @(posedge aclk) begin
        pic_result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected word", m_read_data, 0);
            end else begin
                want = expected_results.pop_front();
                if (m_read_data !== want.bus_byte)
                    report_mismatch("read_data", m_read_data, want.bus_byte);
                if (m_int_request !== want.int_req)
                    report_mismatch("int_request", m_int_request, want.int_req);
                if (m_chosen_line !== want.line)
                    report_mismatch("chosen_line", m_chosen_line, want.line);
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout with %0d words outstanding", expected_results.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        shadow_reset();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_level_counting();
        test_reject_high();
        test_random();
        test_backpressure();
        drain();
        done = 1'b1;
        $display("covered %0d words, %0d acknowledge cycles, %0d polls, %0d results",
            words_sent, acks_sent, polls_sent, results_seen);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

FILE: programmable_interrupt_controller.f
+incdir+src
src/pic_pkg.sv
src/pic_ctrl.sv
src/pic_datapath.sv
src/programmable_interrupt_controller.sv
src/pic_checker.sv
dv/programmable_interrupt_controller_test.sv
